// ===== sv/cursor_list_insert_delete_macros.svh =====
// Assertion macros shared by the cursor list checker.
`ifndef CURSOR_LIST_INSERT_DELETE_MACROS_SVH
`define CURSOR_LIST_INSERT_DELETE_MACROS_SVH

// Checked at every clock edge outside reset.
`define CLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CLI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/cli_pkg.sv =====
// Package with sizes, codes and field widths of the cursor list.
package cli_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned NEW_VALUE_W = 32;
  localparam int unsigned OUT_VALUE_W = 32;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [ACTION_W-1:0] ACT_NEXT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOCUR = 2'd3;

endpackage

// ===== sv/cli_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module cli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/cursor_list_insert_delete.sv =====
// Cursor list: an ordered list in RAM with next, insert and delete at a cursor.
//
// Input channel (s_axis): one beat is one command. tuser carries the action
// (next, insert before cursor, delete at cursor), tdata the value to insert.
// Output channel (m_axis): exactly one beat per command. tdata carries the
// entry reached by a next, zero otherwise; tuser carries the status.
// The list lives in a single RAM with a registered read port. Insert and
// delete move the entries behind the cursor one place per cycle, reading
// one entry while writing the entry that the previous read returned.
// Next reads the RAM and captures the entry; insert shifts the entries
// from the cursor up, then writes the new value; delete shifts those above
// the cursor down; error results and the unused action go straight to the result.
// One command is in work at a time; the shift length, set by the one RAM
// write port, decides the rate.
// The result sits in an output register, so the next command is accepted
// while it waits; if the receiver stalls, a finished result holds in the
// work engine until the output register frees up.
// Reset empties the list and clears the cursor to "no current entry"; the
// RAM needs no clearing, since only entries below the count are ever read.
module cursor_list_insert_delete (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [cli_pkg::NEW_VALUE_W-1:0]  s_axis_tdata,  // [31:0] new_value
  input  logic [cli_pkg::ACTION_W-1:0]     s_axis_tuser,  // [1:0] action
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [cli_pkg::OUT_VALUE_W-1:0]  m_axis_tdata,  // [31:0] out_value
  output logic [cli_pkg::STATUS_W-1:0]     m_axis_tuser   // [1:0] status
);

  import cli_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_NEXT_RD = 3'd1;
  localparam logic [2:0] S_INS_SH  = 3'd2;
  localparam logic [2:0] S_INS_WR  = 3'd3;
  localparam logic [2:0] S_DEL_SH  = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       cur_q, cur_d;
  logic                   cur_none_q, cur_none_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [VALUE_BITS-1:0]  val_q, val_d;
  logic [OUT_VALUE_W-1:0] res_value_q, res_value_d;
  logic [STATUS_W-1:0]    res_status_q, res_status_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_VALUE_W-1:0] out_value_q, out_value_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [VALUE_BITS-1:0]  wr_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [VALUE_BITS-1:0]  rd_data;

  logic                   in_beat;
  logic                   out_free;
  logic [CNT_W-1:0]       next_cur;
  logic [CNT_W-1:0]       ins_cur;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // Cursor targets for next and insert.
  always_comb begin
    next_cur = cur_none_q ? '0 : cur_q + CNT_W'(1);
    if (next_cur >= count_q) begin
      next_cur = '0;
    end
    ins_cur = cur_none_q ? '0 : cur_q;
    if (ins_cur > count_q) begin
      ins_cur = count_q;
    end
  end

  // Command sequencer. Shifts read one entry ahead of the write, so the
  // read and write addresses never meet in the same cycle.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cur_d        = cur_q;
    cur_none_d   = cur_none_q;
    idx_d        = idx_q;
    val_d        = val_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q[IDX_W-1:0];
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_addr      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          res_value_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_DONE;
          case (s_axis_tuser)
            ACT_NEXT: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                cur_d      = next_cur;
                cur_none_d = 1'b0;
                rd_en      = 1'b1;
                rd_addr    = next_cur[IDX_W-1:0];
                state_d    = S_NEXT_RD;
              end
            end
            ACT_INSERT: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                res_status_d = ST_FULL;
              end else begin
                cur_d      = ins_cur;
                cur_none_d = 1'b0;
                val_d      = VALUE_BITS'(s_axis_tdata);
                if (ins_cur == count_q) begin
                  state_d = S_INS_WR;
                end else begin
                  idx_d   = count_q;
                  rd_en   = 1'b1;
                  rd_addr = IDX_W'(count_q - CNT_W'(1));
                  state_d = S_INS_SH;
                end
              end
            end
            ACT_DELETE: begin
              if (cur_none_q || cur_q >= count_q) begin
                res_status_d = ST_NOCUR;
              end else if (cur_q == count_q - CNT_W'(1)) begin
                count_d = count_q - CNT_W'(1);
              end else begin
                idx_d   = cur_q;
                rd_en   = 1'b1;
                rd_addr = IDX_W'(cur_q + CNT_W'(1));
                state_d = S_DEL_SH;
              end
            end
            default: begin
              // Unused action: plain ok result, nothing changes.
            end
          endcase
        end
      end
      S_NEXT_RD: begin
        res_value_d = OUT_VALUE_W'(rd_data);
        state_d     = S_DONE;
      end
      S_INS_SH: begin
        // Entry idx-1 arrived; it moves up to idx.
        wr_en = 1'b1;
        idx_d = idx_q - CNT_W'(1);
        if (idx_q - CNT_W'(1) == cur_q) begin
          state_d = S_INS_WR;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(idx_q - CNT_W'(2));
        end
      end
      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = cur_q[IDX_W-1:0];
        wr_data = val_q;
        count_d = count_q + CNT_W'(1);
        state_d = S_DONE;
      end
      S_DEL_SH: begin
        // Entry idx+1 arrived; it moves down to idx.
        wr_en = 1'b1;
        idx_d = idx_q + CNT_W'(1);
        if (idx_q + CNT_W'(1) == count_q - CNT_W'(1)) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(idx_q + CNT_W'(2));
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register, loaded as a result leaves the sequencer.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_DONE && out_free) begin
      out_valid_d  = 1'b1;
      out_value_d  = res_value_q;
      out_status_d = res_status_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cur_q       <= '0;
      cur_none_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      cur_none_q  <= cur_none_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    val_q        <= val_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  cli_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// ===== sv/cli_checker.sv =====
// Port-level checker for the cursor list and its bind to the top level.
`include "cursor_list_insert_delete_macros.svh"

module cli_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [cli_pkg::OUT_VALUE_W-1:0]  m_axis_tdata,
  input logic [cli_pkg::STATUS_W-1:0]     m_axis_tuser
);

  import cli_pkg::*;

  logic                            in_beat;
  logic                            out_stall;
  logic                            out_err;
  logic [OUT_VALUE_W+STATUS_W-1:0] out_beat;

  // Handshake and payload terms used by the properties below.
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_err   = m_axis_tvalid && (m_axis_tuser != ST_OK);
  assign out_beat  = {m_axis_tdata, m_axis_tuser};

  // No result is offered while reset is held.
  `CLI_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |-> !m_axis_tvalid, "result during reset")

  // A stalled result beat holds its value.
  `CLI_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_beat), "stalled result")

  // One command at a time: the input closes right after a command beat.
  `CLI_ASSERT(a_one_in_work, in_beat |=> !s_axis_tready, "command taken while busy")

  // Every error status comes with a zero value.
  `CLI_ASSERT(a_err_zero, out_err |-> m_axis_tdata == '0, "error result with nonzero value")

endmodule

bind cursor_list_insert_delete cli_checker u_cli_checker (.*);
